### sv/mctg_pkg.sv
// Shared types and constants for the MIDI clock and timecode generator.
// No dependencies; every other file of the block imports this package.
package mctg_pkg;

  localparam int FrameW   = 32;
  localparam int PeriodW  = 20;
  localparam int FpsW     = 5;
  localparam int ModeW    = 2;
  localparam int CmdW     = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 20;
  localparam int ByteW    = 8;
  localparam int DivCntW  = $clog2(FrameW);
  localparam int MsgIdxW  = 2;

  // Input commands
  typedef enum logic [CmdW-1:0] {
    CMD_TICK   = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_START  = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_e;

  // Sync modes; the unused fourth code behaves like MODE_OFF
  typedef enum logic [ModeW-1:0] {
    MODE_OFF   = 2'd0,
    MODE_CLOCK = 2'd1,
    MODE_MTC   = 2'd2,
    MODE_RSVD  = 2'd3
  } mode_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_MODE    = 2'd0,
    CFG_CLOCK_PERIOD = 2'd1,
    CFG_TC_PERIOD    = 2'd2,
    CFG_TC_FPS       = 2'd3
  } cfg_idx_e;

  // Message sequences the datapath can emit
  typedef enum logic [2:0] {
    MSG_CLOCK,
    MSG_QUARTER,
    MSG_FULL_FRAME,
    MSG_SONG_POS,
    MSG_START,
    MSG_STOP
  } msg_kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_CHECK,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic      load_in;
    logic      clr_tc;
    logic      kind_load;
    msg_kind_e kind;
    logic      div_start;
    logic      div_step;
    logic      emit;
    logic      adv_tc;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rewind;
    logic tick_clock;
    logic tick_mtc;
    logic rew_mtc;
    logic rew_clock;
    logic start_clock;
    logic stop_clock;
    logic div_last;
    logic rem_zero;
    logic msg_last;
    logic out_free;
  } dp_status_t;

endpackage

### sv/mctg_ctrl.sv
// Sequencing controller for the MIDI clock and timecode generator.
// Depends on mctg_pkg; drives mctg_dp through dp_cmd_t, reads dp_status_t.
module mctg_ctrl import mctg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = MSG_CLOCK;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.kind_load = 1'b1;
        cmd_o.clr_tc    = status_i.is_rewind;
        state_d         = S_EMIT;
        priority if (status_i.tick_clock) begin
          cmd_o.kind      = MSG_CLOCK;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (status_i.tick_mtc) begin
          cmd_o.kind      = MSG_QUARTER;
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else if (status_i.rew_mtc) begin
          cmd_o.kind = MSG_FULL_FRAME;
        end else if (status_i.rew_clock) begin
          cmd_o.kind = MSG_SONG_POS;
        end else if (status_i.start_clock) begin
          cmd_o.kind = MSG_START;
        end else if (status_i.stop_clock) begin
          cmd_o.kind = MSG_STOP;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = status_i.rem_zero ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (status_i.msg_last) begin
            // Timecode advances after its quarter frames went out
            cmd_o.adv_tc = status_i.tick_mtc;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### sv/mctg_dp.sv
// Datapath for the MIDI clock and timecode generator: config registers,
// serial remainder unit, timecode counters, message builder, output register.
// Depends on mctg_pkg; controlled by mctg_ctrl.
module mctg_dp import mctg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input item
  input  logic [CmdW-1:0]     in_cmd_i,
  input  logic [FrameW-1:0]   in_frame_i,
  input  logic                in_waiting_i,
  // controller link
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  // result item
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ByteW-1:0]    out_status_byte_o,
  output logic [ByteW-1:0]    out_data_one_o,
  output logic                out_data_one_valid_o,
  output logic [ByteW-1:0]    out_data_two_o,
  output logic                out_data_two_valid_o,
  output logic                out_last_o
);

  localparam logic [ByteW-1:0] StQuarter = 8'hF1;
  localparam logic [ByteW-1:0] StSongPos = 8'hF2;
  localparam logic [ByteW-1:0] StClock   = 8'hF8;
  localparam logic [ByteW-1:0] StStart   = 8'hFA;
  localparam logic [ByteW-1:0] StStop    = 8'hFC;
  localparam logic [ByteW-1:0] StSysex   = 8'hF0;
  localparam logic [ByteW-1:0] StEox     = 8'hF7;

  typedef struct packed {
    logic [ByteW-1:0] status_byte;
    logic [ByteW-1:0] data_one;
    logic             data_one_valid;
    logic [ByteW-1:0] data_two;
    logic             data_two_valid;
  } midi_msg_t;

  // ---------------- configuration registers
  logic [ModeW-1:0]   mode_q;
  logic [PeriodW-1:0] clk_per_q;
  logic [PeriodW-1:0] tc_per_q;
  logic [FpsW-1:0]    fps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_OFF;
      clk_per_q <= PeriodW'(1000);
      tc_per_q  <= PeriodW'(3528);
      fps_q     <= FpsW'(25);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SYNC_MODE:    mode_q    <= cfg_data_i[ModeW-1:0];
        CFG_CLOCK_PERIOD: clk_per_q <= cfg_data_i[PeriodW-1:0];
        CFG_TC_PERIOD:    tc_per_q  <= cfg_data_i[PeriodW-1:0];
        CFG_TC_FPS:       fps_q     <= cfg_data_i[FpsW-1:0];
        default:          ;
      endcase
    end
  end

  // ---------------- input item
  cmd_e              cmd_q;
  logic              wait_q;
  logic [FrameW-1:0] sh_q;      // frame, shifted out MSB first by the divider

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q  <= cmd_e'(in_cmd_i);
      wait_q <= in_waiting_i;
    end
  end

  logic is_clock, is_mtc;
  assign is_clock = (mode_q == MODE_CLOCK);
  assign is_mtc   = (mode_q == MODE_MTC);

  // ---------------- serial remainder, one frame bit per cycle
  logic [PeriodW-1:0] div_q, rem_q;
  logic [DivCntW-1:0] cnt_q;
  logic [PeriodW:0]   trial;
  logic               fits;

  assign trial = {rem_q, sh_q[FrameW-1]};
  assign fits  = (trial >= {1'b0, div_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sh_q <= in_frame_i;
    end else if (cmd_i.div_step) begin
      sh_q <= {sh_q[FrameW-2:0], 1'b0};
    end
    if (cmd_i.div_start) begin
      div_q <= (cmd_i.kind == MSG_CLOCK) ? clk_per_q : tc_per_q;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= fits ? PeriodW'(trial - {1'b0, div_q}) : trial[PeriodW-1:0];
      cnt_q <= cnt_q + DivCntW'(1);
    end
  end

  // ---------------- timecode counters
  logic [4:0] fc_q;
  logic [5:0] sec_q, min_q;
  logic [7:0] hr_q;
  logic [4:0] fc_inc;
  logic [5:0] sec_inc, min_inc;

  assign fc_inc  = fc_q + 5'd1;
  assign sec_inc = sec_q + 6'd1;
  assign min_inc = min_q + 6'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q  <= '0;
      sec_q <= '0;
      min_q <= '0;
      hr_q  <= '0;
    end else if (cmd_i.clr_tc) begin
      fc_q  <= '0;
      sec_q <= '0;
      min_q <= '0;
      hr_q  <= '0;
    end else if (cmd_i.adv_tc) begin
      if (fc_inc >= fps_q) begin
        fc_q <= '0;
        if (sec_inc >= 6'd60) begin
          sec_q <= '0;
          if (min_inc >= 6'd60) begin
            min_q <= '0;
            hr_q  <= hr_q + 8'd1;
          end else begin
            min_q <= min_inc;
          end
        end else begin
          sec_q <= sec_inc;
        end
      end else begin
        fc_q <= fc_inc;
      end
    end
  end

  // ---------------- message sequencing
  msg_kind_e          kind_q;
  logic [MsgIdxW-1:0] idx_q;
  logic [MsgIdxW-1:0] last_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.kind_load) begin
      kind_q <= cmd_i.kind;
      idx_q  <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + MsgIdxW'(1);
    end
  end

  always_comb begin
    unique case (kind_q)
      MSG_QUARTER, MSG_FULL_FRAME: last_idx = 2'd3;
      MSG_START:                   last_idx = 2'd1;
      default:                     last_idx = 2'd0;
    endcase
  end

  function automatic midi_msg_t msg_one(input logic [ByteW-1:0] st);
    midi_msg_t m;
    m = '0;
    m.status_byte = st;
    return m;
  endfunction

  function automatic midi_msg_t msg_two(input logic [ByteW-1:0] st,
                                       input logic [ByteW-1:0] d1);
    midi_msg_t m;
    m = '0;
    m.status_byte    = st;
    m.data_one       = d1;
    m.data_one_valid = 1'b1;
    return m;
  endfunction

  function automatic midi_msg_t msg_three(input logic [ByteW-1:0] st,
                                          input logic [ByteW-1:0] d1,
                                          input logic [ByteW-1:0] d2);
    midi_msg_t m;
    m = '0;
    m.status_byte    = st;
    m.data_one       = d1;
    m.data_one_valid = 1'b1;
    m.data_two       = d2;
    m.data_two_valid = 1'b1;
    return m;
  endfunction

  midi_msg_t msg;

  always_comb begin
    msg = msg_one(StClock);
    unique case (kind_q)
      MSG_CLOCK: msg = msg_one(StClock);
      MSG_QUARTER: begin
        // even frames carry frame and seconds, odd frames minutes and hours
        unique case ({fc_q[0], idx_q})
          3'b000:  msg = msg_two(StQuarter, {4'h0, fc_q[3:0]});
          3'b001:  msg = msg_two(StQuarter, {4'h1, 3'b000, fc_q[4]});
          3'b010:  msg = msg_two(StQuarter, {4'h2, sec_q[3:0]});
          3'b011:  msg = msg_two(StQuarter, {4'h3, 2'b00, sec_q[5:4]});
          3'b100:  msg = msg_two(StQuarter, {4'h4, min_q[3:0]});
          3'b101:  msg = msg_two(StQuarter, {4'h5, 2'b00, min_q[5:4]});
          3'b110:  msg = msg_two(StQuarter, {4'h6, hr_q[3:0]});
          default: msg = msg_two(StQuarter, {4'h7, hr_q[7:4]});
        endcase
      end
      MSG_FULL_FRAME: begin
        unique case (idx_q)
          2'd0:    msg = msg_three(StSysex, 8'h7F, 8'h00);
          2'd1:    msg = msg_three(8'h01, 8'h01, 8'h00);
          2'd2:    msg = msg_three(8'h00, 8'h00, 8'h00);
          default: msg = msg_one(StEox);
        endcase
      end
      MSG_SONG_POS: msg = msg_three(StSongPos, 8'h00, 8'h00);
      MSG_START: msg = (idx_q == 2'd0) ? msg_one(StStart)
                                       : msg_three(StSongPos, 8'h00, 8'h00);
      MSG_STOP: msg = msg_one(StStop);
      default: msg = msg_one(StClock);
    endcase
  end

  // ---------------- output register
  logic      out_valid_q;
  midi_msg_t out_q;
  logic      out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q      <= msg;
      out_last_q <= (idx_q == last_idx);
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_status_byte_o    = out_q.status_byte;
  assign out_data_one_o       = out_q.data_one;
  assign out_data_one_valid_o = out_q.data_one_valid;
  assign out_data_two_o       = out_q.data_two;
  assign out_data_two_valid_o = out_q.data_two_valid;
  assign out_last_o           = out_last_q;

  // ---------------- status
  always_comb begin
    status_o             = '0;
    status_o.is_rewind   = (cmd_q == CMD_REWIND);
    status_o.tick_clock  = (cmd_q == CMD_TICK) && !wait_q && is_clock && (clk_per_q != '0);
    status_o.tick_mtc    = (cmd_q == CMD_TICK) && !wait_q && is_mtc && (tc_per_q != '0);
    status_o.rew_mtc     = (cmd_q == CMD_REWIND) && is_mtc;
    status_o.rew_clock   = (cmd_q == CMD_REWIND) && is_clock;
    status_o.start_clock = (cmd_q == CMD_START) && is_clock;
    status_o.stop_clock  = (cmd_q == CMD_STOP) && is_clock;
    status_o.div_last    = (cnt_q == DivCntW'(FrameW - 1));
    status_o.rem_zero    = (rem_q == '0);
    status_o.msg_last    = (idx_q == last_idx);
    status_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

### sv/midi_clock_and_timecode_generator_top.sv
// Top level of the MIDI clock and timecode generator: stream ports, config port.
// Depends on mctg_pkg, mctg_ctrl and mctg_dp.
//
// Takes one command beat at a time (tick, rewind, start, stop) and returns
// the MIDI sync messages it causes, one message per output beat, with tlast
// on the final message of each command; a command that causes nothing gives
// no output beat. A tick in clock or timecode mode checks the audio frame
// against the selected period with a serial remainder unit that consumes one
// frame bit per cycle, so such a tick passes through the decode, divide
// and check states and emits its messages only when the frame hits the
// period. Rewind, start, stop and ticks that skip the check (sequencer
// waiting, sync off, zero period) go from decode straight to emitting
// their messages, if any. The output register lets the block take the
// next command while the last message still waits; a stalled master side
// stretches the emit cycles. Configuration writes are always ready and
// must only happen while no command is in flight.
module midi_clock_and_timecode_generator_top import mctg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // command stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [31:0]         s_axis_tdata_i,   // [31:0] current_frame
  input  logic [2:0]          s_axis_tuser_i,   // [1:0] cmd, [2] waiting
  // MIDI message stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [23:0]         m_axis_tdata_o,   // [7:0] status_byte, [15:8] data_one,
                                                // [23:16] data_two
  output logic [1:0]          m_axis_tuser_o,   // [0] data_one_valid, [1] data_two_valid
  output logic                m_axis_tlast_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_st;
  logic       in_ready;

  // Config registers take a write in any cycle
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = in_ready;

  mctg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (in_ready),
    .status_i   (dp_st),
    .cmd_o      (dp_cmd)
  );

  mctg_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_cmd_i             (s_axis_tuser_i[1:0]),
    .in_frame_i           (s_axis_tdata_i),
    .in_waiting_i         (s_axis_tuser_i[2]),
    .cmd_i                (dp_cmd),
    .status_o             (dp_st),
    .out_valid_o          (m_axis_tvalid_o),
    .out_ready_i          (m_axis_tready_i),
    .out_status_byte_o    (m_axis_tdata_o[7:0]),
    .out_data_one_o       (m_axis_tdata_o[15:8]),
    .out_data_one_valid_o (m_axis_tuser_o[0]),
    .out_data_two_o       (m_axis_tdata_o[23:16]),
    .out_data_two_valid_o (m_axis_tuser_o[1]),
    .out_last_o           (m_axis_tlast_o)
  );

`ifndef ASSERT_OFF
  // The block decodes each accepted command before it takes another
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("command accepted while previous one still decoding");

  // The controller loads a message only into a free output register
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> dp_st.out_free)
    else $error("message overwrote a pending output beat");

  // An absent first data byte goes out as zero
  a_absent_bytes_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> m_axis_tdata_o[15:8] == 8'h00)
    else $error("data_one nonzero while flagged absent");
`endif

endmodule

### tb/midi_sync_checker.sv
// Checker for the MIDI clock and timecode generator: predicts the messages of
// every command beat and compares them with the MIDI message stream.
// Depends on mctg_pkg for the command, mode and register index codes.
`timescale 1ns / 100ps

module midi_sync_checker import mctg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [31:0]         s_tdata_i,   // [31:0] current_frame
  input  logic [2:0]          s_tuser_i,   // [1:0] cmd, [2] waiting
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [23:0]         m_tdata_i,   // [7:0] status, [15:8] data one, [23:16] data two
  input  logic [1:0]          m_tuser_i,   // [0] data one valid, [1] data two valid
  input  logic                m_tlast_i,
  output int                  mismatches_o,
  output int                  pending_o
);

  localparam logic [7:0] ST_QUARTER  = 8'hF1;
  localparam logic [7:0] ST_SONGPOS  = 8'hF2;
  localparam logic [7:0] ST_CLOCK    = 8'hF8;
  localparam logic [7:0] ST_START    = 8'hFA;
  localparam logic [7:0] ST_STOP     = 8'hFC;
  localparam logic [7:0] ST_SYSEX    = 8'hF0;
  localparam logic [7:0] ST_EOX      = 8'hF7;
  localparam logic [7:0] SYX_RT_ID   = 8'h7F;
  localparam logic [7:0] SYX_DEVICE  = 8'h00;
  localparam logic [7:0] SYX_MTC_ID  = 8'h01;
  localparam logic [7:0] SYX_FULL_FR = 8'h01;
  localparam logic [7:0] SYX_ZERO    = 8'h00;

  // quarter-frame piece numbers, upper nibble of the data byte
  localparam logic [3:0] QF_FRAME_LO = 4'h0;
  localparam logic [3:0] QF_FRAME_HI = 4'h1;
  localparam logic [3:0] QF_SEC_LO   = 4'h2;
  localparam logic [3:0] QF_SEC_HI   = 4'h3;
  localparam logic [3:0] QF_MIN_LO   = 4'h4;
  localparam logic [3:0] QF_MIN_HI   = 4'h5;
  localparam logic [3:0] QF_HOUR_LO  = 4'h6;
  localparam logic [3:0] QF_HOUR_HI  = 4'h7;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] data1;
    logic       data1_vld;
    logic [7:0] data2;
    logic       data2_vld;
    logic       last;
  } midi_msg_t;

  logic [ModeW-1:0]   sync_mode;
  logic [PeriodW-1:0] clock_div;
  logic [PeriodW-1:0] tc_div;
  logic [FpsW-1:0]    tc_fps;
  logic [4:0]         tc_frame;
  logic [5:0]         tc_sec;
  logic [5:0]         tc_min;
  logic [7:0]         tc_hour;

  midi_msg_t msg_queue[$];
  midi_msg_t burst[4];
  int        burst_len;

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    mismatches_o++;
    $display("%0t ns: mismatch on %s, expected %0h, got %0h", $realtime, field, want, got);
  endtask

  task automatic add_msg(logic [7:0] st, logic [7:0] d1, logic d1v, logic [7:0] d2, logic d2v);
    burst[burst_len] = '{status: st, data1: d1v ? d1 : 8'h00, data1_vld: d1v,
                         data2: d2v ? d2 : 8'h00, data2_vld: d2v, last: 1'b0};
    burst_len++;
  endtask

  task automatic step_timecode();
    tc_frame = tc_frame + 5'd1;
    if (tc_frame >= tc_fps) begin
      tc_frame = '0;
      tc_sec++;
      if (tc_sec >= 6'd60) begin
        tc_sec = '0;
        tc_min++;
        if (tc_min >= 6'd60) begin
          tc_min = '0;
          tc_hour = tc_hour + 8'd1;
        end
      end
    end
  endtask

  task automatic predict_tick(logic [31:0] frame, logic waiting);
    if (waiting) return;
    if (sync_mode == MODE_CLOCK) begin
      if (clock_div != '0 && (frame % {12'd0, clock_div}) == 32'd0)
        add_msg(ST_CLOCK, '0, 1'b0, '0, 1'b0);
    end else if (sync_mode == MODE_MTC) begin
      if (tc_div == '0 || (frame % {12'd0, tc_div}) != 32'd0) return;
      if (!tc_frame[0]) begin
        add_msg(ST_QUARTER, {QF_FRAME_LO, tc_frame[3:0]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_FRAME_HI, 3'd0, tc_frame[4]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_SEC_LO, tc_sec[3:0]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_SEC_HI, 2'd0, tc_sec[5:4]}, 1'b1, '0, 1'b0);
      end else begin
        add_msg(ST_QUARTER, {QF_MIN_LO, tc_min[3:0]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_MIN_HI, 2'd0, tc_min[5:4]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_HOUR_LO, tc_hour[3:0]}, 1'b1, '0, 1'b0);
        add_msg(ST_QUARTER, {QF_HOUR_HI, tc_hour[7:4]}, 1'b1, '0, 1'b0);
      end
      step_timecode();
    end
  endtask

  task automatic predict_command(cmd_e cmd, logic [31:0] frame, logic waiting);
    burst_len = 0;
    case (cmd)
      CMD_TICK: predict_tick(frame, waiting);
      CMD_REWIND: begin
        tc_frame = '0;
        tc_sec   = '0;
        tc_min   = '0;
        tc_hour  = '0;
        if (sync_mode == MODE_MTC) begin
          add_msg(ST_SYSEX, SYX_RT_ID, 1'b1, SYX_DEVICE, 1'b1);
          add_msg(SYX_MTC_ID, SYX_FULL_FR, 1'b1, SYX_ZERO, 1'b1);
          add_msg(SYX_ZERO, SYX_ZERO, 1'b1, SYX_ZERO, 1'b1);
          add_msg(ST_EOX, '0, 1'b0, '0, 1'b0);
        end else if (sync_mode == MODE_CLOCK) begin
          add_msg(ST_SONGPOS, 8'h00, 1'b1, 8'h00, 1'b1);
        end
      end
      CMD_START: begin
        if (sync_mode == MODE_CLOCK) begin
          add_msg(ST_START, '0, 1'b0, '0, 1'b0);
          add_msg(ST_SONGPOS, 8'h00, 1'b1, 8'h00, 1'b1);
        end
      end
      default: begin
        if (sync_mode == MODE_CLOCK) add_msg(ST_STOP, '0, 1'b0, '0, 1'b0);
      end
    endcase
    for (int i = 0; i < burst_len; i++) begin
      if (i == burst_len - 1) burst[i].last = 1'b1;
      msg_queue.push_back(burst[i]);
    end
  endtask

  task automatic check_beat();
    midi_msg_t want;
    if (msg_queue.size() == 0) begin
      report_mismatch("message beat with none pending", 32'd0, {8'd0, m_tdata_i});
      return;
    end
    want = msg_queue.pop_front();
    if (m_tdata_i[7:0] != want.status)
      report_mismatch("status_byte", 32'(want.status), 32'(m_tdata_i[7:0]));
    if (m_tdata_i[15:8] != want.data1)
      report_mismatch("data_one", 32'(want.data1), 32'(m_tdata_i[15:8]));
    if (m_tuser_i[0] != want.data1_vld)
      report_mismatch("data_one_valid", 32'(want.data1_vld), 32'(m_tuser_i[0]));
    if (m_tdata_i[23:16] != want.data2)
      report_mismatch("data_two", 32'(want.data2), 32'(m_tdata_i[23:16]));
    if (m_tuser_i[1] != want.data2_vld)
      report_mismatch("data_two_valid", 32'(want.data2_vld), 32'(m_tuser_i[1]));
    if (m_tlast_i != want.last)
      report_mismatch("last", 32'(want.last), 32'(m_tlast_i));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode    = MODE_OFF;
      clock_div    = 20'd1000;
      tc_div       = 20'd3528;
      tc_fps       = 5'd25;
      tc_frame     = '0;
      tc_sec       = '0;
      tc_min       = '0;
      tc_hour      = '0;
      mismatches_o = 0;
      pending_o    = 0;
      msg_queue.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_SYNC_MODE:    sync_mode = cfg_data_i[ModeW-1:0];
          CFG_CLOCK_PERIOD: clock_div = cfg_data_i[PeriodW-1:0];
          CFG_TC_PERIOD:    tc_div    = cfg_data_i[PeriodW-1:0];
          default:          tc_fps    = cfg_data_i[FpsW-1:0];
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_beat();
      if (s_tvalid_i && s_tready_i)
        predict_command(cmd_e'(s_tuser_i[1:0]), s_tdata_i, s_tuser_i[2]);
      pending_o = msg_queue.size();
    end
  end

endmodule

### tb/midi_clock_and_timecode_generator_top_test.sv
// Testbench top for the MIDI clock and timecode generator: drives commands,
// configuration and back-pressure, and gives the verdict.
// Depends on mctg_pkg, midi_clock_and_timecode_generator_top, midi_sync_checker.
`timescale 1ns / 100ps

module midi_clock_and_timecode_generator_top_test;
  import mctg_pkg::*;

  // No beat on any channel for this many cycles means the block has hung.
  localparam int QuietLimit = 2000;
  // Cycles to let a tick that sends nothing drain before touching registers.
  localparam int DrainCycles = 60;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [31:0]         s_tdata;    // [31:0] current_frame
  logic [2:0]          s_tuser;    // [1:0] cmd, [2] waiting
  logic                m_tvalid;
  logic                m_tready;
  logic [23:0]         m_tdata;    // [7:0] status, [15:8] data one, [23:16] data two
  logic [1:0]          m_tuser;    // [0] data one valid, [1] data two valid
  logic                m_tlast;

  int mismatches;
  int pending;
  int quiet_cycles;
  int ready_hold;
  bit idle_en;

  // Stimulus-side copy of the settings, used only to aim frames at the period
  logic [ModeW-1:0]   cur_mode;
  logic [PeriodW-1:0] cur_clock_div;
  logic [PeriodW-1:0] cur_tc_div;

  midi_clock_and_timecode_generator_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  midi_sync_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Master-side back-pressure: hold tready low or high for random bursts,
  // and keep it high once idling is switched off for the closing phase.
  always @(negedge clk) begin
    if (!idle_en) begin
      m_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= $urandom_range(0, 6);
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 5);
    end
  end

  // Watchdog: count cycles in which no channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QuietLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drop the command valid, then wait until every predicted message has come
  // out and a message-less tick has had time to finish.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all four registers while the block is idle.
  task automatic configure(logic [ModeW-1:0] mode, logic [PeriodW-1:0] clock_div,
                           logic [PeriodW-1:0] tc_div, logic [FpsW-1:0] fps);
    wait_idle();
    write_reg(CFG_SYNC_MODE, {{(CfgDataW-ModeW){1'b0}}, mode});
    write_reg(CFG_CLOCK_PERIOD, clock_div);
    write_reg(CFG_TC_PERIOD, tc_div);
    write_reg(CFG_TC_FPS, {{(CfgDataW-FpsW){1'b0}}, fps});
    @(negedge clk);
    cfg_valid     <= 1'b0;
    cur_mode      = mode;
    cur_clock_div = clock_div;
    cur_tc_div    = tc_div;
  endtask

  // Present one command beat, with an optional gap ahead of it, and hold it
  // until the block takes it. Valid stays high into the next call.
  task automatic send_cmd(cmd_e cmd, logic [31:0] frame, logic waiting);
    @(negedge clk);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= frame;
    s_tuser  <= {waiting, cmd};
    do @(posedge clk); while (!s_tready);
  endtask

  // Half the frames land on a multiple of the period so that messages flow;
  // the rest are the extremes or fully random.
  function automatic logic [31:0] pick_frame(logic [PeriodW-1:0] period);
    int unsigned pick;
    int unsigned top_mult;
    pick = $urandom_range(0, 9);
    if (pick < 5 && period != '0) begin
      top_mult = 32'hFFFF_FFFF / {12'd0, period};
      return {12'd0, period} * $urandom_range(0, top_mult);
    end
    if (pick == 5) return 32'd0;
    if (pick == 6) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic run_random(int count, bit ticks_only);
    int unsigned pick;
    cmd_e        cmd;
    logic [PeriodW-1:0] period;
    period = (cur_mode == MODE_MTC) ? cur_tc_div : cur_clock_div;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (ticks_only || pick < 14) cmd = CMD_TICK;
      else if (pick < 16)          cmd = CMD_REWIND;
      else if (pick < 18)          cmd = CMD_START;
      else                         cmd = CMD_STOP;
      send_cmd(cmd, pick_frame(period), $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SYNC_MODE;
    cfg_data      = '0;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    m_tready      = 1'b0;
    ready_hold    = 0;
    idle_en       = 1'b1;
    cur_mode      = MODE_OFF;
    cur_clock_div = 20'd1000;
    cur_tc_div    = 20'd3528;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: sync off, so every command is silent.
    send_cmd(CMD_TICK, 32'd0, 1'b0);
    send_cmd(CMD_REWIND, 32'd0, 1'b0);
    send_cmd(CMD_START, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 32'd0, 1'b0);

    // Clock master with the shortest period, every command at least once.
    configure(MODE_CLOCK, 20'd1, 20'd3528, 5'd25);
    send_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_TICK, 32'd0, 1'b1);          // waiting sequencer: no clock
    send_cmd(CMD_REWIND, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_START, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 32'd0, 1'b0);

    // Zero clock period sends nothing.
    configure(MODE_CLOCK, 20'd0, 20'd3528, 5'd25);
    send_cmd(CMD_TICK, 32'd0, 1'b0);

    // Longest clock period: a hit at zero and at the period, a miss below it.
    configure(MODE_CLOCK, 20'hFFFFF, 20'd3528, 5'd25);
    send_cmd(CMD_TICK, 32'd0, 1'b0);
    send_cmd(CMD_TICK, 32'h000F_FFFF, 1'b0);
    send_cmd(CMD_TICK, 32'h000F_FFFE, 1'b0);

    // Timecode with zero fps: every advance wraps the frame into seconds.
    configure(MODE_MTC, 20'hFFFFF, 20'd1, 5'd0);
    send_cmd(CMD_TICK, 32'd5, 1'b0);
    send_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b0);
    send_cmd(CMD_REWIND, 32'd0, 1'b0);

    // Largest fps field: odd frame counts give minute and hour pieces.
    configure(MODE_MTC, 20'hFFFFF, 20'd1, 5'd31);
    send_cmd(CMD_TICK, 32'd0, 1'b0);
    send_cmd(CMD_TICK, 32'd1, 1'b0);
    send_cmd(CMD_TICK, 32'd2, 1'b0);

    // Zero timecode period: nothing sent, counters hold.
    configure(MODE_MTC, 20'd1000, 20'd0, 5'd25);
    send_cmd(CMD_TICK, 32'd0, 1'b0);

    // Longest timecode period.
    configure(MODE_MTC, 20'd1000, 20'hFFFFF, 5'd25);
    send_cmd(CMD_TICK, 32'd0, 1'b0);
    send_cmd(CMD_TICK, 32'hFFFF_FFFF, 1'b0);

    // Unused mode code behaves like sync off.
    configure(MODE_RSVD, 20'd1, 20'd1, 5'd25);
    send_cmd(CMD_TICK, 32'd0, 1'b0);
    send_cmd(CMD_REWIND, 32'd0, 1'b0);
    send_cmd(CMD_START, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 32'd0, 1'b0);

    // Random phases, each under its own settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin
          configure(MODE_CLOCK, 20'($urandom_range(1, 6)), 20'd3528, 5'd25);
          run_random(20, 1'b0);
        end
        1: begin
          configure(MODE_MTC, 20'd1000, 20'($urandom_range(1, 4)), 5'd30);
          run_random(20, 1'b0);
        end
        2: begin
          configure(MODE_CLOCK, 20'hFFFFF, 20'd1, 5'd1);
          run_random(16, 1'b0);
        end
        3: begin
          // Long run of ticks at two frames per second: carries seconds into
          // minutes so the minute pieces change.
          configure(MODE_MTC, 20'd7, 20'd1, 5'd2);
          run_random(140, 1'b1);
        end
        4: begin
          configure($urandom_range(0, 1) ? MODE_RSVD : MODE_OFF, 20'd2, 20'd2, 5'd25);
          run_random(12, 1'b0);
        end
        5: begin
          configure(MODE_MTC, 20'($urandom), 20'($urandom_range(1, 20'hFFFFF)),
                    5'($urandom_range(0, 31)));
          run_random(18, 1'b0);
        end
        6: begin
          configure(MODE_CLOCK, 20'($urandom_range(1, 20'hFFFFF)), 20'($urandom),
                    5'($urandom));
          run_random(18, 1'b0);
        end
        default: begin
          // Closing phase runs at full rate on both sides.
          idle_en = 1'b0;
          configure(MODE_MTC, 20'd3, 20'($urandom_range(1, 5)), 5'($urandom_range(1, 30)));
          run_random(20, 1'b0);
        end
      endcase
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/mctg_pkg.sv
sv/mctg_ctrl.sv
sv/mctg_dp.sv
sv/midi_clock_and_timecode_generator_top.sv
tb/midi_sync_checker.sv
tb/midi_clock_and_timecode_generator_top_test.sv
